// ===== rtl/life_cellular_automaton_step_defines.svh =====
// Assertion helpers shared by the life step RTL.
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCAS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcas: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LCAS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcas: next-cycle check failed");

`endif

// ===== rtl/lcas_pkg.sv =====
package lcas_pkg;

    // Default grid edge length.
    localparam int GRID_DIM_DEF = 64;

    // Width of the row and column index fields.
    localparam int IDX_W = 6;

    // Action codes.
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // Neighborhood and B3/S23 rule constants.
    localparam int NBR_CNT = 8;
    localparam int NBR_W   = $clog2(NBR_CNT + 1);
    localparam logic [NBR_W-1:0] SURVIVE_MIN = NBR_W'(2);
    localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic wr_cell;
        logic rd_cell;
        logic sweep;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sweep_end;
        logic out_free;
    } t_dp_sts;

    function automatic logic life_next(input logic alive, input logic [NBR_W-1:0] nbr);
        logic res;
        if (alive) begin
            res = (nbr == SURVIVE_MIN) || (nbr == BIRTH_CNT);
        end else begin
            res = (nbr == BIRTH_CNT);
        end
        return res;
    endfunction

endpackage

// ===== rtl/lcas_ctrl.sv =====
`include "life_cellular_automaton_step_defines.svh"

module lcas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    output logic              o_ready,
    output lcas_pkg::t_dp_cmd o_cmd,
    input  lcas_pkg::t_dp_sts i_sts
);
    import lcas_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_action)
                        ACT_WRITE:   n_state = S_WRITE;
                        ACT_READ:    n_state = S_READ;
                        ACT_ADVANCE: n_state = S_SWEEP;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.wr_cell = 1'b1;
                n_state       = S_FIN;
            end
            S_READ: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_FIN;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LCAS_ASSERT_NEXT(a_adv_enters_sweep, i_clk, i_rst_n, (r_state == S_IDLE) && i_valid && (i_action == ACT_ADVANCE), r_state == S_SWEEP)
    `LCAS_ASSERT_NEXT(a_sweep_ends, i_clk, i_rst_n, (r_state == S_SWEEP) && i_sts.sweep_end, r_state == S_FIN)
    `LCAS_ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, (r_state == S_FIN) && i_sts.out_free, (r_state == S_IDLE) && o_ready)

endmodule

// ===== rtl/lcas_dpath.sv =====
`include "life_cellular_automaton_step_defines.svh"

module lcas_dpath #(
    parameter int GRID_DIM = lcas_pkg::GRID_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lcas_pkg::t_dp_cmd         i_cmd,
    output lcas_pkg::t_dp_sts         o_sts,
    input  logic [1:0]                i_action,
    input  logic [lcas_pkg::IDX_W-1:0] i_row,
    input  logic [lcas_pkg::IDX_W-1:0] i_column,
    input  logic                      i_cell_value,
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic                      o_cell_out,
    output logic                      o_done_res
);
    import lcas_pkg::*;

    localparam int AW = $clog2(GRID_DIM);
    localparam int CW = $clog2(GRID_DIM + 1);

    // Grid storage: one row per word, per-row valid bits stand in for reset.
    logic [GRID_DIM-1:0] r_mem [GRID_DIM];
    logic [GRID_DIM-1:0] r_row_vld;
    logic [GRID_DIM-1:0] r_rd_q;
    logic                r_rd_vld;

    logic [AW-1:0]       r_row_idx;
    logic [AW-1:0]       r_col_idx;
    logic                r_val;
    logic                r_inside;
    logic [CW-1:0]       r_cnt;
    logic [GRID_DIM-1:0] r_win_prev;
    logic [GRID_DIM-1:0] r_win_cur;
    logic                r_res_cell;
    logic                r_res_done;
    logic                r_out_vld;
    logic                r_out_cell;
    logic                r_out_done;

    logic                in_inside;
    logic [CW-1:0]       cnt_inc;
    logic [CW-1:0]       cnt_dec;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [GRID_DIM-1:0] rd_row;
    logic [GRID_DIM-1:0] win_next;
    logic [GRID_DIM+1:0] pad_prev;
    logic [GRID_DIM+1:0] pad_cur;
    logic [GRID_DIM+1:0] pad_next;
    logic [GRID_DIM-1:0] new_row;
    logic [GRID_DIM-1:0] cell_row;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [GRID_DIM-1:0] wr_data;

    assign in_inside = (32'(i_row) < 32'(GRID_DIM)) && (32'(i_column) < 32'(GRID_DIM));
    assign cnt_inc   = r_cnt + CW'(1);
    assign cnt_dec   = r_cnt - CW'(1);
    assign rd_row    = r_rd_vld ? r_rd_q : '0;
    assign win_next  = (r_cnt == CW'(GRID_DIM)) ? '0 : rd_row;
    assign pad_prev  = {1'b0, r_win_prev, 1'b0};
    assign pad_cur   = {1'b0, r_win_cur, 1'b0};
    assign pad_next  = {1'b0, win_next, 1'b0};

    for (genvar j = 0; j < GRID_DIM; j++) begin : g_lane
        logic [NBR_W-1:0] nbr;
        assign nbr = NBR_W'(pad_prev[j]) + NBR_W'(pad_prev[j+1]) + NBR_W'(pad_prev[j+2])
                   + NBR_W'(pad_cur[j])                          + NBR_W'(pad_cur[j+2])
                   + NBR_W'(pad_next[j]) + NBR_W'(pad_next[j+1]) + NBR_W'(pad_next[j+2]);
        assign new_row[j] = life_next(r_win_cur[j], nbr);
    end

    // Read port: the item's row on capture, one row ahead during a sweep.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.capture) begin
            rd_en   = (i_action == ACT_ADVANCE) || in_inside;
            rd_addr = (i_action == ACT_ADVANCE) ? '0 : AW'(i_row);
        end else if (i_cmd.sweep) begin
            rd_en   = (cnt_inc < CW'(GRID_DIM));
            rd_addr = AW'(cnt_inc);
        end
    end

    always_comb begin
        cell_row            = rd_row;
        cell_row[r_col_idx] = r_val;
    end

    // Write port: merged cell row, or the finished row one behind the sweep.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.wr_cell) begin
            wr_en   = r_inside;
            wr_addr = r_row_idx;
            wr_data = cell_row;
        end else if (i_cmd.sweep) begin
            wr_en   = (r_cnt != '0);
            wr_addr = AW'(cnt_dec);
            wr_data = new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q   <= r_mem[rd_addr];
            r_rd_vld <= r_row_vld[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row_idx  <= AW'(i_row);
            r_col_idx  <= AW'(i_column);
            r_val      <= i_cell_value;
            r_inside   <= in_inside;
            r_cnt      <= '0;
            r_win_prev <= '0;
            r_win_cur  <= '0;
            r_res_cell <= 1'b0;
            r_res_done <= (i_action != ACT_NONE);
        end else if (i_cmd.rd_cell) begin
            r_res_cell <= r_inside ? rd_row[r_col_idx] : 1'b0;
        end else if (i_cmd.sweep) begin
            r_win_prev <= r_win_cur;
            r_win_cur  <= win_next;
            r_cnt      <= cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cell <= r_res_cell;
            r_out_done <= r_res_done;
        end
    end

    assign o_sts.sweep_end = (r_cnt == CW'(GRID_DIM));
    assign o_sts.out_free  = !r_out_vld || i_ready;
    assign o_valid         = r_out_vld;
    assign o_cell_out      = r_out_cell;
    assign o_done_res      = r_out_done;

    `LCAS_ASSERT_NOW(a_out_slot_free, i_clk, i_rst_n, i_cmd.out_load, !r_out_vld || i_ready)
    `LCAS_ASSERT_NOW(a_sweep_no_overlap, i_clk, i_rst_n, i_cmd.sweep && rd_en && wr_en, rd_addr != wr_addr)

endmodule

// ===== rtl/life_cellular_automaton_step.sv =====
// B3/S23 life engine on a GRID_DIM x GRID_DIM grid of one-bit cells, all dead
// after reset, with no wrap-around at the edges. Each input transfer carries an
// action: write one cell, read one cell, or advance the whole grid one
// generation; each gives exactly one result transfer (cell_out, done_res). One
// item is in work at a time. A read or write moves through row read, row update
// and result load; an advance runs a row sweep that computes one full row per
// cycle through the single-read, single-write grid memory, its last sweep step
// writing back the bottom row, then loads the result; the unused action code
// goes straight to result load and answers done_res = 0. The next item is taken
// as soon as the result sits in the output register, even if it is not yet
// taken; no new item is accepted while one is still in work.
// Per-row valid bits make reset instant: no clearing pass is needed.
module life_cellular_automaton_step #(
    parameter int GRID_DIM = lcas_pkg::GRID_DIM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel.
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic [lcas_pkg::IDX_W-1:0] i_row,
    input  logic [lcas_pkg::IDX_W-1:0] i_column,
    input  logic                       i_cell_value,
    // Result channel.
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_cell_out,
    output logic                       o_done_res
);
    import lcas_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: decodes the action on each input transfer, steps the row
    // sweep and hands the result to the output register once it is free.
    lcas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    // Grid memory, three-row window with one neighbor counter per column,
    // and the result register that decouples the output side.
    lcas_dpath #(
        .GRID_DIM (GRID_DIM)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cell_value (i_cell_value),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_cell_out   (o_cell_out),
        .o_done_res   (o_done_res)
    );

endmodule
